// File: rtl/static_prefix_code_byte_packer_defines.svh
// Assertion macros used by the byte packer RTL.
`ifndef STATIC_PREFIX_CODE_BYTE_PACKER_DEFINES_SVH
`define STATIC_PREFIX_CODE_BYTE_PACKER_DEFINES_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define SPCBP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spcbp check failed");

// Check that cons holds in the cycle after ante, outside reset.
`define SPCBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spcbp check failed");

`endif

// File: rtl/spcbp_pkg.sv
// Types, codes and fixed code tables of the prefix code byte packer.
package spcbp_pkg;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  localparam logic TBL_STREET = 1'b0;
  localparam logic TBL_PRON   = 1'b1;

  localparam logic [3:0] FULL_BYTE_BITS = 4'd8;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic       table_select;
  } item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic [3:0] valid_bits;
  } result_t;

  // Codeword lookup result: MSB aligned code and its length.
  typedef struct packed {
    logic       hit;
    logic [7:0] code;
    logic [3:0] len;
  } code_t;

  // One step handed from the input stage to the packer.
  typedef struct packed {
    logic  go;
    logic  command;
    code_t lookup;
  } step_t;

  function automatic code_t hit_code(input logic [7:0] code, input logic [3:0] len);
    code_t r;
    r.hit  = 1'b1;
    r.code = code;
    r.len  = len;
    return r;
  endfunction

  function automatic code_t street_code(input logic [7:0] ch);
    code_t r;
    r = '{hit: 1'b0, code: 8'h00, len: 4'd0};
    unique case (ch)
      8'h45: r = hit_code(8'hE0, 4'd3);
      8'h53: r = hit_code(8'hC0, 4'd3);
      8'h52: r = hit_code(8'hA0, 4'd3);
      8'h41: r = hit_code(8'h98, 4'd5);
      8'h0A: r = hit_code(8'h90, 4'd5);
      8'h54: r = hit_code(8'h88, 4'd5);
      8'h4E: r = hit_code(8'h80, 4'd5);
      8'h48: r = hit_code(8'h78, 4'd5);
      8'h4C: r = hit_code(8'h70, 4'd5);
      8'h47: r = hit_code(8'h34, 4'd6);
      8'h49: r = hit_code(8'h30, 4'd6);
      8'h20: r = hit_code(8'h2C, 4'd6);
      8'h4F: r = hit_code(8'h28, 4'd6);
      8'h4D: r = hit_code(8'h10, 4'd6);
      8'h44: r = hit_code(8'h6E, 4'd7);
      8'h42: r = hit_code(8'h6C, 4'd7);
      8'h57: r = hit_code(8'h6A, 4'd7);
      8'h55: r = hit_code(8'h68, 4'd7);
      8'h43: r = hit_code(8'h66, 4'd7);
      8'h4B: r = hit_code(8'h64, 4'd7);
      8'h2D: r = hit_code(8'h62, 4'd7);
      8'h46: r = hit_code(8'h60, 4'd7);
      8'h50: r = hit_code(8'h5E, 4'd7);
      8'h5A: r = hit_code(8'h5C, 4'd7);
      8'hDC: r = hit_code(8'h5A, 4'd7);
      8'hD6: r = hit_code(8'h58, 4'd7);
      8'hC4: r = hit_code(8'h56, 4'd7);
      8'h56: r = hit_code(8'h54, 4'd7);
      8'h4A: r = hit_code(8'h52, 4'd7);
      8'h59: r = hit_code(8'h50, 4'd7);
      8'h2E: r = hit_code(8'h4E, 4'd7);
      8'h58: r = hit_code(8'h4C, 4'd7);
      8'h51: r = hit_code(8'h4A, 4'd7);
      8'h31: r = hit_code(8'h48, 4'd7);
      8'h32: r = hit_code(8'h46, 4'd7);
      8'h27: r = hit_code(8'h44, 4'd7);
      8'h33: r = hit_code(8'h42, 4'd7);
      8'h34: r = hit_code(8'h40, 4'd7);
      8'h36: r = hit_code(8'h3E, 4'd7);
      8'h35: r = hit_code(8'h3C, 4'd7);
      8'h30: r = hit_code(8'h3A, 4'd7);
      8'h39: r = hit_code(8'h38, 4'd7);
      8'h37: r = hit_code(8'h06, 4'd7);
      8'h38: r = hit_code(8'h04, 4'd7);
      8'h28: r = hit_code(8'h1B, 4'd8);
      8'h29: r = hit_code(8'h1A, 4'd8);
      8'h2C: r = hit_code(8'h19, 4'd8);
      8'h2F: r = hit_code(8'h18, 4'd8);
      8'hC2: r = hit_code(8'h17, 4'd8);
      8'hC7: r = hit_code(8'h16, 4'd8);
      8'hD8: r = hit_code(8'h15, 4'd8);
      8'hCA: r = hit_code(8'h14, 4'd8);
      8'hCB: r = hit_code(8'h08, 4'd8);
      8'hC6: r = hit_code(8'h09, 4'd8);
      8'hD4: r = hit_code(8'h01, 4'd8);
      default: r = '{hit: 1'b0, code: 8'h00, len: 4'd0};
    endcase
    return r;
  endfunction

  // The pronunciation table has one empty slot (symbol zero, no bits); it
  // adds nothing to the accumulator, so it reads as a miss here.
  function automatic code_t pron_code(input logic [7:0] ch);
    code_t r;
    r = '{hit: 1'b0, code: 8'h00, len: 4'd0};
    unique case (ch)
      8'h2E: r = hit_code(8'hE0, 4'd3);
      8'h52: r = hit_code(8'hC0, 4'd3);
      8'h27: r = hit_code(8'hA0, 4'd3);
      8'h24: r = hit_code(8'h98, 4'd5);
      8'h3A: r = hit_code(8'h90, 4'd5);
      8'h61: r = hit_code(8'h88, 4'd5);
      8'h0A: r = hit_code(8'h80, 4'd5);
      8'h74: r = hit_code(8'h78, 4'd5);
      8'h5F: r = hit_code(8'h70, 4'd5);
      8'h6E: r = hit_code(8'h34, 4'd6);
      8'h73: r = hit_code(8'h30, 4'd6);
      8'h6B: r = hit_code(8'h2C, 4'd6);
      8'h6C: r = hit_code(8'h28, 4'd6);
      8'h53: r = hit_code(8'h24, 4'd6);
      8'h26: r = hit_code(8'h20, 4'd6);
      8'h32: r = hit_code(8'h10, 4'd6);
      8'h65: r = hit_code(8'h0C, 4'd6);
      8'h6D: r = hit_code(8'h08, 4'd6);
      8'h76: r = hit_code(8'h04, 4'd6);
      8'h62: r = hit_code(8'h5A, 4'd7);
      8'h45: r = hit_code(8'h58, 4'd7);
      8'h69: r = hit_code(8'h56, 4'd7);
      8'h49: r = hit_code(8'h54, 4'd7);
      8'h68: r = hit_code(8'h52, 4'd7);
      8'h66: r = hit_code(8'h50, 4'd7);
      8'h64: r = hit_code(8'h4E, 4'd7);
      8'h4F: r = hit_code(8'h4C, 4'd7);
      8'h67: r = hit_code(8'h4A, 4'd7);
      8'h6F: r = hit_code(8'h48, 4'd7);
      8'h70: r = hit_code(8'h46, 4'd7);
      8'h75: r = hit_code(8'h44, 4'd7);
      8'h55: r = hit_code(8'h42, 4'd7);
      8'h7A: r = hit_code(8'h40, 4'd7);
      8'h4B: r = hit_code(8'h3E, 4'd7);
      8'h79: r = hit_code(8'h3C, 4'd7);
      8'h43: r = hit_code(8'h3A, 4'd7);
      8'h2B: r = hit_code(8'h38, 4'd7);
      8'h3F: r = hit_code(8'h1B, 4'd8);
      8'h78: r = hit_code(8'h1A, 4'd8);
      8'h59: r = hit_code(8'h19, 4'd8);
      8'h6A: r = hit_code(8'h18, 4'd8);
      8'h25: r = hit_code(8'h17, 4'd8);
      8'h7E: r = hit_code(8'h16, 4'd8);
      8'h5A: r = hit_code(8'h15, 4'd8);
      8'h41: r = hit_code(8'h14, 4'd8);
      default: r = '{hit: 1'b0, code: 8'h00, len: 4'd0};
    endcase
    return r;
  endfunction

endpackage

// File: rtl/spcbp_lookup.sv
// Codeword lookup in the selected fixed code table.
module spcbp_lookup (
  input  logic                [7:0] char_code,
  input  logic                      table_select,
  output spcbp_pkg::code_t          lookup
);

  // Pick the table and look the character up.
  always_comb begin
    unique case (table_select)
      spcbp_pkg::TBL_STREET: lookup = spcbp_pkg::street_code(char_code);
      spcbp_pkg::TBL_PRON:   lookup = spcbp_pkg::pron_code(char_code);
      default:               lookup = spcbp_pkg::street_code(char_code);
    endcase
  end

endmodule

// File: rtl/spcbp_packer.sv
// Bit accumulator, byte packing and result register.
`include "static_prefix_code_byte_packer_defines.svh"

module spcbp_packer (
  input  logic               clk,
  input  logic               rst,
  input  spcbp_pkg::step_t   step,
  output logic               ready,
  output logic               result_valid,
  input  logic               result_stall,
  output spcbp_pkg::result_t result
);

  logic [7:0]  acc;
  logic [2:0]  pend;
  logic [7:0]  acc_next;
  logic [2:0]  pend_next;
  logic        emit;
  logic [7:0]  emit_byte;
  logic [3:0]  emit_bits;
  logic [3:0]  total;
  logic [15:0] shifted;
  logic [7:0]  acc_or;

  // Advance whenever the result register is empty or being drained.
  assign ready = !result_valid || !result_stall;

  // Split the codeword at the pending position: high byte joins, low byte spills.
  assign shifted = {step.lookup.code, 8'h00} >> pend;
  assign acc_or  = acc | shifted[15:8];
  assign total   = {1'b0, pend} + step.lookup.len;

  // Work out the next state and the beat to emit.
  always_comb begin
    acc_next  = acc;
    pend_next = pend;
    emit      = 1'b0;
    emit_byte = acc;
    emit_bits = {1'b0, pend};
    if (step.go) begin
      priority if (step.command == spcbp_pkg::CMD_FLUSH) begin
        emit      = (pend != 3'd0);
        acc_next  = 8'h00;
        pend_next = 3'd0;
      end else if (step.lookup.hit) begin
        pend_next = total[2:0];
        if (total[3]) begin
          emit      = 1'b1;
          emit_byte = acc_or;
          emit_bits = spcbp_pkg::FULL_BYTE_BITS;
          acc_next  = shifted[7:0];
        end else begin
          acc_next  = acc_or;
        end
      end
    end
  end

  // Hold the accumulator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= 8'h00;
      pend <= 3'd0;
    end else begin
      acc  <= acc_next;
      pend <= pend_next;
    end
  end

  // Load the result register when it can take a new beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && emit) begin
      result.packed_byte <= emit_byte;
      result.valid_bits  <= emit_bits;
    end
  end

  // Bits past the pending count stay zero.
  `SPCBP_ASSERT_IMPL(a_acc_tail_zero, 1'b1, (acc & (8'hFF >> pend)) == 8'h00)
  // A result beat carries one to eight bits.
  `SPCBP_ASSERT_IMPL(a_bits_range, result_valid,
                     result.valid_bits != 4'd0 && result.valid_bits <= 4'd8)
  // An encode that emits gives a full byte.
  `SPCBP_ASSERT_NEXT(a_encode_full, step.go && emit && step.command == spcbp_pkg::CMD_ENCODE,
                     result_valid && result.valid_bits == spcbp_pkg::FULL_BYTE_BITS)
  // A flush leaves the accumulator empty.
  `SPCBP_ASSERT_NEXT(a_flush_clears, step.go && step.command == spcbp_pkg::CMD_FLUSH,
                     pend == 3'd0 && acc == 8'h00)

endmodule

// File: rtl/static_prefix_code_byte_packer.sv
// Top level of the static prefix code byte packer.
//
// Items come in on item/item_valid/item_stall; each carries a command
// (encode one character or flush), the character byte and a table choice.
// Packed bytes leave on result/result_valid/result_stall, MSB first, with
// valid_bits = 8 for a byte filled by encoding and 1..7 for a flush.
// A beat is taken at a clock edge with valid high and stall low.
//
// An item taken into the input register goes through the table lookup and
// shift-or packing there; the accumulator updates and any result loads
// into the result register at the edge on which the packer takes the item.
// One item per cycle while the result register is not stalled. Characters
// missing from the chosen table and flushes with nothing pending produce no
// beat.
//
// Reset (synchronous, rst high) empties the accumulator and both stages.
// When the receiver stalls, the result register holds its beat and the
// pipeline stops; item_stall rises once the input register is also full.
module static_prefix_code_byte_packer (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  spcbp_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output spcbp_pkg::result_t result
);

  logic              s1_valid;
  spcbp_pkg::item_t  s1_item;
  logic              ready;
  spcbp_pkg::code_t  lookup;
  spcbp_pkg::step_t  step;

  // Stall only when the input register is full and cannot advance.
  assign item_stall = s1_valid && !ready;

  // Capture the incoming beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  spcbp_lookup u_lookup (
    .char_code    (s1_item.char_code),
    .table_select (s1_item.table_select),
    .lookup       (lookup)
  );

  // Hand the registered item to the packer when it can advance.
  always_comb begin
    step.go      = s1_valid && ready;
    step.command = s1_item.command;
    step.lookup  = lookup;
  end

  spcbp_packer u_packer (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .ready        (ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: tb/static_prefix_code_byte_packer_test.sv
// Self-checking testbench for the static prefix code byte packer.
module static_prefix_code_byte_packer_test;

  localparam int STREET_SYMBOLS = 55;
  localparam int PRON_SYMBOLS   = 46;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int LONG_HOLD      = 300;
  localparam int CYCLE_LIMIT    = 200000;

  // Code tables as {symbol, codeword, length}; first entry sits at the top bits.
  localparam logic [STREET_SYMBOLS*24-1:0] STREET_TAB = {
    24'h45E003, 24'h53C003, 24'h52A003, 24'h419805, 24'h0A9005,
    24'h548805, 24'h4E8005, 24'h487805, 24'h4C7005, 24'h473406,
    24'h493006, 24'h202C06, 24'h4F2806, 24'h4D1006, 24'h446E07,
    24'h426C07, 24'h576A07, 24'h556807, 24'h436607, 24'h4B6407,
    24'h2D6207, 24'h466007, 24'h505E07, 24'h5A5C07, 24'hDC5A07,
    24'hD65807, 24'hC45607, 24'h565407, 24'h4A5207, 24'h595007,
    24'h2E4E07, 24'h584C07, 24'h514A07, 24'h314807, 24'h324607,
    24'h274407, 24'h334207, 24'h344007, 24'h363E07, 24'h353C07,
    24'h303A07, 24'h393807, 24'h370607, 24'h380407, 24'h281B08,
    24'h291A08, 24'h2C1908, 24'h2F1808, 24'hC21708, 24'hC71608,
    24'hD81508, 24'hCA1408, 24'hCB0808, 24'hC60908, 24'hD40108
  };

  // The last pronunciation slot is empty: symbol zero with no bits.
  localparam logic [PRON_SYMBOLS*24-1:0] PRON_TAB = {
    24'h2EE003, 24'h52C003, 24'h27A003, 24'h249805, 24'h3A9005,
    24'h618805, 24'h0A8005, 24'h747805, 24'h5F7005, 24'h6E3406,
    24'h733006, 24'h6B2C06, 24'h6C2806, 24'h532406, 24'h262006,
    24'h321006, 24'h650C06, 24'h6D0806, 24'h760406, 24'h625A07,
    24'h455807, 24'h695607, 24'h495407, 24'h685207, 24'h665007,
    24'h644E07, 24'h4F4C07, 24'h674A07, 24'h6F4807, 24'h704607,
    24'h754407, 24'h554207, 24'h7A4007, 24'h4B3E07, 24'h793C07,
    24'h433A07, 24'h2B3807, 24'h3F1B08, 24'h781A08, 24'h591908,
    24'h6A1808, 24'h251708, 24'h7E1608, 24'h5A1508, 24'h411408,
    24'h000000
  };

  typedef struct {
    spcbp_pkg::item_t beat;
    int               gap;
    bit               drain;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  spcbp_pkg::item_t   item = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  spcbp_pkg::result_t result;

  pending_t           send_q[$];
  spcbp_pkg::result_t byte_expect[$];

  // Predicted packer state.
  logic [7:0] acc_bits = 8'h00;
  logic [2:0] acc_fill = 3'd0;

  int items_offered = 0;
  int items_taken   = 0;
  int total_items   = 0;
  int results_seen  = 0;
  int results_noted = 0;
  int flushes_taken = 0;
  int silent_items  = 0;
  int errors        = 0;
  int gap_left      = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  bit long_hold_done = 1'b0;

  static_prefix_code_byte_packer u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Fetch entry i of the chosen table as {symbol, codeword, length}.
  function automatic logic [23:0] code_entry(input logic sel, input int i);
    if (sel == spcbp_pkg::TBL_PRON) return PRON_TAB[(PRON_SYMBOLS - 1 - i)*24 +: 24];
    return STREET_TAB[(STREET_SYMBOLS - 1 - i)*24 +: 24];
  endfunction

  // Look up a character; the first matching entry wins.
  function automatic void code_lookup(input logic [7:0] ch, input logic sel,
                                      output logic hit, output logic [7:0] code,
                                      output logic [3:0] len);
    logic [23:0] ent;
    int n;
    hit  = 1'b0;
    code = 8'h00;
    len  = 4'd0;
    n = (sel == spcbp_pkg::TBL_PRON) ? PRON_SYMBOLS : STREET_SYMBOLS;
    for (int i = 0; i < n; i++) begin
      ent = code_entry(sel, i);
      if (!hit && ent[23:16] == ch) begin
        hit  = 1'b1;
        code = ent[15:8];
        len  = ent[3:0];
      end
    end
  endfunction

  // Advance the predicted accumulator by one beat and report any packed byte.
  task automatic pack_step(input spcbp_pkg::item_t it, output bit emit,
                           output spcbp_pkg::result_t res);
    logic       hit;
    logic [7:0] code;
    logic [3:0] len;
    logic [3:0] total;
    logic [3:0] rem;
    emit = 1'b0;
    res  = '0;
    if (it.command == spcbp_pkg::CMD_FLUSH) begin
      if (acc_fill != 3'd0) begin
        emit            = 1'b1;
        res.packed_byte = acc_bits;
        res.valid_bits  = {1'b0, acc_fill};
        acc_bits        = 8'h00;
        acc_fill        = 3'd0;
      end
    end else begin
      code_lookup(it.char_code, it.table_select, hit, code, len);
      if (hit) begin
        acc_bits = acc_bits | (code >> acc_fill);
        total    = {1'b0, acc_fill} + len;
        if (total < 4'd8) begin
          acc_fill = total[2:0];
        end else begin
          emit            = 1'b1;
          res.packed_byte = acc_bits;
          res.valid_bits  = spcbp_pkg::FULL_BYTE_BITS;
          rem             = total - 4'd8;
          acc_bits        = code << (len - rem);
          acc_fill        = rem[2:0];
        end
      end
    end
  endtask

  function automatic void queue_beat(input logic cmd, input logic [7:0] ch,
                                     input logic sel, input bit drain, input bit quiet);
    pending_t p;
    p.beat.command      = cmd;
    p.beat.char_code    = ch;
    p.beat.table_select = sel;
    p.gap   = quiet ? 0 : $urandom_range(0, 11);
    p.drain = drain;
    send_q.push_back(p);
  endfunction

  // Track accepted input beats and predict their results.
  always @(posedge clk) begin
    bit                 emit;
    spcbp_pkg::result_t res;
    if (!rst && item_valid && !item_stall) begin
      pack_step(item, emit, res);
      if (emit) byte_expect.push_back(res);
      else silent_items++;
      if (item.command == spcbp_pkg::CMD_FLUSH) flushes_taken++;
      items_taken++;
    end
  end

  // Drive input beats at the falling edge.
  always @(negedge clk) begin
    pending_t nxt;
    if (!rst) begin
      if (item_valid && items_taken == items_offered) begin
        // beat went through: present the next one at once or idle first
        if (send_q.size() > 0 && send_q[0].gap == 0 && !send_q[0].drain) begin
          nxt = send_q.pop_front();
          item <= nxt.beat;
          items_offered++;
        end else begin
          item_valid <= 1'b0;
          gap_left = (send_q.size() > 0 && send_q[0].gap > 0) ? send_q[0].gap - 1 : 0;
        end
      end else if (!item_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (send_q.size() > 0 &&
                     !(send_q[0].drain && byte_expect.size() != 0)) begin
          nxt = send_q.pop_front();
          item       <= nxt.beat;
          item_valid <= 1'b1;
          items_offered++;
        end
      end
    end
  end

  // Check each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    spcbp_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (byte_expect.size() == 0) begin
        $error("unexpected result beat: packed_byte %h valid_bits %0d",
               result.packed_byte, result.valid_bits);
        errors++;
      end else begin
        want = byte_expect.pop_front();
        if (result.packed_byte !== want.packed_byte) begin
          $error("packed_byte mismatch: expected %h actual %h",
                 want.packed_byte, result.packed_byte);
          errors++;
        end
        if (result.valid_bits !== want.valid_bits) begin
          $error("valid_bits mismatch: expected %0d actual %0d",
                 want.valid_bits, result.valid_bits);
          errors++;
        end
      end
      results_seen++;
    end
  end

  // Drive receiver stall: a random hold after each result outside the stall-free stretches, one long hold.
  always @(negedge clk) begin
    if (!rst) begin
      if (results_seen != results_noted) begin
        results_noted = results_seen;
        if (!long_hold_done && results_seen >= 200) begin
          long_hold_done = 1'b1;
          hold_left = LONG_HOLD;
        end else if ((results_seen / 120) % 5 == 4) begin
          hold_left = 0;
        end else begin
          hold_left = $urandom_range(0, 11);
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end
      result_stall <= (hold_left > 0);
    end
  end

  // Bound the run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [23:0] ent;
    logic        sel;
    int          r;
    bit          quiet;

    // Directed: extremes, table edges and the corner cases of packing.
    queue_beat(spcbp_pkg::CMD_FLUSH,  8'hFF, spcbp_pkg::TBL_PRON,   1'b0, 1'b0); // nothing pending
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h45, spcbp_pkg::TBL_STREET, 1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h45, spcbp_pkg::TBL_STREET, 1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h45, spcbp_pkg::TBL_STREET, 1'b0, 1'b0); // spill over
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'hCB, spcbp_pkg::TBL_STREET, 1'b0, 1'b0); // one zero bit
    queue_beat(spcbp_pkg::CMD_FLUSH,  8'h00, spcbp_pkg::TBL_STREET, 1'b0, 1'b0); // all-zero byte
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'hD4, spcbp_pkg::TBL_STREET, 1'b0, 1'b0); // fill from empty
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h41, spcbp_pkg::TBL_PRON,   1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h00, spcbp_pkg::TBL_STREET, 1'b0, 1'b0); // unknown
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'hFF, spcbp_pkg::TBL_STREET, 1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h00, spcbp_pkg::TBL_PRON,   1'b0, 1'b0); // empty slot
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'hFF, spcbp_pkg::TBL_PRON,   1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h2E, spcbp_pkg::TBL_PRON,   1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h76, spcbp_pkg::TBL_PRON,   1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h38, spcbp_pkg::TBL_STREET, 1'b0, 1'b0); // exact fill
    queue_beat(spcbp_pkg::CMD_FLUSH,  8'h00, spcbp_pkg::TBL_STREET, 1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h3F, spcbp_pkg::TBL_PRON,   1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h4D, spcbp_pkg::TBL_STREET, 1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h52, spcbp_pkg::TBL_PRON,   1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_ENCODE, 8'h4D, spcbp_pkg::TBL_STREET, 1'b0, 1'b0);
    queue_beat(spcbp_pkg::CMD_FLUSH,  8'hFF, spcbp_pkg::TBL_PRON,   1'b0, 1'b0); // seven pending
    queue_beat(spcbp_pkg::CMD_FLUSH,  8'hFF, spcbp_pkg::TBL_PRON,   1'b0, 1'b0);

    // Random: mostly table symbols, some noise bytes and flushes.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = ((i / 150) % 4 == 2);
      sel = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_beat(spcbp_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)), sel,
                   i == 0 || i == 800, quiet);
      end else if (r < 14) begin
        queue_beat(spcbp_pkg::CMD_ENCODE, 8'($urandom_range(0, 255)), sel,
                   i == 0 || i == 800, quiet);
      end else begin
        ent = code_entry(sel, $urandom_range(0, (sel == spcbp_pkg::TBL_PRON) ?
                                             PRON_SYMBOLS - 1 : STREET_SYMBOLS - 1));
        queue_beat(spcbp_pkg::CMD_ENCODE, ent[23:16], sel, i == 0 || i == 800, quiet);
      end
    end
    queue_beat(spcbp_pkg::CMD_FLUSH, 8'h00, spcbp_pkg::TBL_STREET, 1'b0, 1'b0);
    total_items = send_q.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all beats and results, then let the pipeline settle.
    while (items_taken < total_items || byte_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (byte_expect.size() != 0) begin
      $error("%0d predicted results never arrived", byte_expect.size());
      errors++;
    end

    $display("Ran %0d input beats (%0d flushes, %0d without a result) in %0d cycles",
             items_taken, flushes_taken, silent_items, cycle_count);
    $display("Checked %0d packed bytes across both code tables", results_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
